// File: src/mwbf_pkg.sv
// Shared types, byte codes and slot table for the whitespace and bullet filter.
package mwbf_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
    localparam int unsigned QIDX_W = $clog2(QDEPTH);

    typedef logic [7:0] t_byte;

    localparam t_byte BYTE_BLANK  = 8'h20;
    localparam t_byte BYTE_TAB    = 8'h09;
    localparam t_byte BYTE_NL     = 8'h0A;
    localparam t_byte BYTE_STAR   = 8'h2A;
    localparam t_byte BYTE_PLUS   = 8'h2B;
    localparam t_byte BYTE_MINUS  = 8'h2D;
    localparam t_byte BULLET_0    = 8'hE2;
    localparam t_byte BULLET_1    = 8'h80;
    localparam t_byte BULLET_2    = 8'hA2;

    // Output slots of one request, emitted lowest index first.
    localparam int unsigned NSLOT       = 8;
    localparam int unsigned SLOT_PARA_0 = 0;
    localparam int unsigned SLOT_PARA_1 = 1;
    localparam int unsigned SLOT_LEAD   = 2;
    localparam int unsigned SLOT_BUL_0  = 3;
    localparam int unsigned SLOT_BUL_1  = 4;
    localparam int unsigned SLOT_BUL_2  = 5;
    localparam int unsigned SLOT_SPACE  = 6;
    localparam int unsigned SLOT_CHAR   = 7;

    typedef logic [NSLOT-1:0] t_slots;

    localparam t_byte SLOT_BYTE [NSLOT] = '{
        BYTE_NL, BYTE_NL, BYTE_NL, BULLET_0, BULLET_1, BULLET_2, BYTE_BLANK, 8'h00
    };

    typedef struct packed {
        t_slots slots;
        t_byte  ch;
    } t_cmd;

    // Byte for a one-hot slot pick; the char slot carries the request's own byte.
    function automatic t_byte slot_byte(input t_slots pick, input t_byte ch);
        t_byte b;
        b = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (pick[i]) begin
                b = b | ((i == SLOT_CHAR) ? ch : SLOT_BYTE[i]);
            end
        end
        return b;
    endfunction

endpackage

// File: src/mwbf_front.sv
// Front end: classifies each input byte, tracks spacing state, builds output requests.
module mwbf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  mwbf_pkg::t_byte      i_byte,
    output logic                 o_push,
    output mwbf_pkg::t_cmd       o_cmd
);
    import mwbf_pkg::*;

    logic [1:0] r_blank, n_blank;
    logic [1:0] r_nl, n_nl;
    logic       r_line_clear, n_line_clear;
    logic       r_none_yet, n_none_yet;

    logic       is_blank, is_nl, is_marker;
    logic       brk, para, le_eff, bullet_case;
    logic [1:0] nl_eff, nl_after;
    t_cmd       cmd;

    assign is_blank  = (i_byte == BYTE_BLANK) || (i_byte == BYTE_TAB);
    assign is_nl     = (i_byte == BYTE_NL);
    assign is_marker = (i_byte == BYTE_STAR) || (i_byte == BYTE_PLUS) ||
                       (i_byte == BYTE_MINUS);

    // Hard break: newline after text on a line that ended in two or more blanks.
    assign brk = !r_line_clear && r_blank[1];

    // Forget leading newlines before any output.
    assign nl_eff      = r_none_yet ? 2'd0 : r_nl;
    assign para        = nl_eff[1];
    assign le_eff      = para || r_line_clear;
    assign nl_after    = para ? 2'd0 : nl_eff;
    assign bullet_case = (le_eff || (nl_after != 2'd0)) && is_marker;

    always_comb begin
        cmd          = '0;
        cmd.ch       = i_byte;
        n_blank      = r_blank;
        n_nl         = r_nl;
        n_line_clear = r_line_clear;
        n_none_yet   = r_none_yet;
        if (is_blank) begin
            n_blank = r_blank[1] ? 2'd2 : r_blank + 2'd1;
        end else if (is_nl) begin
            cmd.slots[SLOT_CHAR] = brk;
            n_line_clear = r_line_clear || brk;
            n_none_yet   = r_none_yet && !brk;
            n_nl         = r_nl[1] ? 2'd2 : r_nl + 2'd1;
            n_blank      = 2'd0;
        end else begin
            cmd.slots[SLOT_PARA_0] = para;
            cmd.slots[SLOT_PARA_1] = para;
            cmd.slots[SLOT_LEAD]   = bullet_case;
            cmd.slots[SLOT_BUL_0]  = bullet_case;
            cmd.slots[SLOT_BUL_1]  = bullet_case;
            cmd.slots[SLOT_BUL_2]  = bullet_case;
            cmd.slots[SLOT_SPACE]  = !bullet_case && !le_eff &&
                                     ((r_blank != 2'd0) || (nl_after != 2'd0));
            cmd.slots[SLOT_CHAR]   = !bullet_case;
            n_line_clear = 1'b0;
            n_none_yet   = 1'b0;
            n_blank      = 2'd0;
            n_nl         = 2'd0;
        end
    end

    assign o_push = i_accept && (cmd.slots != '0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank      <= 2'd0;
            r_nl         <= 2'd0;
            r_line_clear <= 1'b1;
            r_none_yet   <= 1'b1;
        end else if (i_accept) begin
            r_blank      <= n_blank;
            r_nl         <= n_nl;
            r_line_clear <= n_line_clear;
            r_none_yet   <= n_none_yet;
        end
    end

endmodule

// File: src/mwbf_queue.sv
// Short shift queue of output requests between front and back ends.
module mwbf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mwbf_pkg::t_cmd  i_cmd,
    output logic            o_not_full,
    output logic            o_valid,
    output mwbf_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import mwbf_pkg::*;

    t_cmd              r_q [QDEPTH];
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] wr_pos;
    logic [QIDX_W-1:0] wr_idx;
    logic              pop;

    assign o_not_full = (r_count != QCNT_W'(QDEPTH));
    assign o_valid    = (r_count != '0);
    assign o_cmd      = r_q[0];
    assign pop        = i_pop && o_valid;
    assign wr_pos     = r_count - QCNT_W'(pop);
    assign wr_idx     = wr_pos[QIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(pop);
        end
    end

    // Advance toward the head on pop; write behind the last kept entry.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (i_push && (wr_idx == QIDX_W'(i))) begin
                r_q[i] <= i_cmd;
            end else if (pop && (i < QDEPTH - 1)) begin
                r_q[i] <= r_q[(i < QDEPTH - 1) ? i + 1 : i];
            end
        end
    end

endmodule

// File: src/mwbf_back.sv
// Back end: expands requests into registered output bytes, one per cycle unless stalled.
module mwbf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  mwbf_pkg::t_cmd  i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output mwbf_pkg::t_byte o_byte,
    output logic            o_last
);
    import mwbf_pkg::*;

    t_slots r_mask;
    t_byte  r_ch;
    logic   r_out_valid;
    t_byte  r_out_byte;
    logic   r_out_last;

    logic   use_head, load;
    t_slots cur, pick, rest;
    t_byte  cur_ch;

    assign use_head = (r_mask == '0);
    assign cur      = use_head ? (i_head_valid ? i_head.slots : '0) : r_mask;
    assign cur_ch   = use_head ? i_head.ch : r_ch;
    assign pick     = cur & (~cur + t_slots'(1));
    assign rest     = cur & ~pick;
    assign load     = !r_out_valid || i_ready;
    assign o_pop    = load && use_head && i_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mask      <= '0;
        end else if (load) begin
            r_out_valid <= (cur != '0);
            r_mask      <= rest;
        end
    end

    // Hold the request byte while its slots drain.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= slot_byte(pick, cur_ch);
            r_out_last <= (rest == '0);
            if (use_head) begin
                r_ch <= cur_ch;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

// File: src/markdown_whitespace_bullet_filter.sv
// Top level of the markdown whitespace and bullet filter.
// Takes one text byte per request on the input channel and produces zero to six
// formatted bytes on the output channel, o_last_of_run marking the final byte of
// each input byte's run. An input byte is accepted in any cycle the four-entry
// request queue has room, so bytes that give one or no output flow at one per
// cycle while the output keeps up; the back end drains one output byte per cycle
// while i_ready is high, so long runs of expanding bytes fill the queue and hold
// o_ready low until it drains. An accepted byte's request is registered in the
// queue and then in the back end's output register before its first byte shows.
module markdown_whitespace_bullet_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);
    import mwbf_pkg::*;

    logic accept;
    logic push, not_full, head_valid, pop;
    t_cmd push_cmd, head_cmd;

    assign o_ready = not_full;
    assign accept  = i_valid && not_full;

    mwbf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    mwbf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (push_cmd),
        .o_not_full (not_full),
        .o_valid    (head_valid),
        .o_cmd      (head_cmd),
        .i_pop      (pop)
    );

    mwbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_byte       (o_out_byte),
        .o_last       (o_last_of_run)
    );

endmodule

// File: src/mwbf_checker.sv
// Port-level checker for the whitespace and bullet filter, bound to the top level.
module mwbf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run
);
    import mwbf_pkg::*;

    // Output is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A stalled output byte holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_last_of_run))
        else $error("stalled output changed");

    // Blanks are swallowed: a space only appears as a separator before text.
    a_space_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_byte == BYTE_BLANK) |-> !o_last_of_run)
        else $error("space ended a run");

    a_no_tab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_byte != BYTE_TAB))
        else $error("tab reached output");

endmodule

bind markdown_whitespace_bullet_filter mwbf_checker u_mwbf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run)
);

// File: sim/tb_top.sv
// Self-checking testbench for the markdown whitespace and bullet filter.
module tb_top;
    import mwbf_pkg::*;

    localparam int HOLD_FOR_DRAIN = -1;     // queue entry: wait for the output to drain
    localparam int RANDOM_ITEMS   = 385;
    localparam int CALM_TAIL      = 60;
    localparam int LONG_HOLD      = 100;
    localparam int CYCLE_LIMIT    = 300000;

    typedef struct packed {
        t_byte data;
        logic  is_last;
    } t_out_rec;

    logic  i_clk     = 1'b0;
    logic  i_rst_n   = 1'b0;
    logic  i_valid   = 1'b0;
    logic  i_ready   = 1'b0;
    t_byte i_in_byte = '0;
    logic  o_ready;
    logic  o_valid;
    t_byte o_out_byte;
    logic  o_last_of_run;

    // Formatter state kept by the testbench.
    logic [1:0] blank_run;
    logic [1:0] nl_run;
    logic       line_clear;
    logic       no_output_yet;

    int       pending[$];
    t_out_rec expected_out[$];
    int       n_fail     = 0;
    int       n_taken    = 0;
    int       cycles     = 0;
    logic     out_idle   = 1'b1;
    logic     calm       = 1'b0;
    int       send_gap   = 0;
    int       drain_wait = 0;
    int       ready_run  = 0;
    int       stall_run  = 0;
    int       hold_left  = 0;
    logic     hold_done  = 1'b0;

    markdown_whitespace_bullet_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // Advance the formatter by one source byte and queue the bytes it yields.
    function automatic void format_byte(input t_byte b);
        t_byte    run[$];
        logic     marker;
        t_out_rec rec;
        marker = (b == BYTE_STAR) || (b == BYTE_PLUS) || (b == BYTE_MINUS);
        if (b == BYTE_BLANK || b == BYTE_TAB) begin
            blank_run = (blank_run == 2'd2) ? 2'd2 : blank_run + 2'd1;
        end else if (b == BYTE_NL) begin
            if (!line_clear && blank_run == 2'd2) begin
                run = {run, BYTE_NL};
                line_clear = 1'b1;
            end
            nl_run    = (nl_run == 2'd2) ? 2'd2 : nl_run + 2'd1;
            blank_run = 2'd0;
        end else begin
            // Forget newlines that came before any output at all.
            if (no_output_yet) nl_run = 2'd0;
            if (nl_run == 2'd2) begin
                run = {run, BYTE_NL, BYTE_NL};
                line_clear = 1'b1;
                nl_run     = 2'd0;
            end
            if ((line_clear || nl_run != 2'd0) && marker) begin
                // nl_run is below two here, so the list item always gets its own newline
                run = {run, BYTE_NL, BULLET_0, BULLET_1, BULLET_2};
            end else begin
                if (!line_clear && (blank_run != 2'd0 || nl_run != 2'd0))
                    run = {run, BYTE_BLANK};
                run = {run, b};
            end
            line_clear = 1'b0;
            blank_run  = 2'd0;
            nl_run     = 2'd0;
        end
        if (run.size() != 0) no_output_yet = 1'b0;
        foreach (run[i]) begin
            rec.data    = run[i];
            rec.is_last = (i == run.size() - 1);
            expected_out = {expected_out, rec};
        end
    endfunction

    // Request driver.
    always @(posedge i_clk) begin : drive_requests
        logic  offer;
        t_byte nb;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_in_byte <= '0;
        end else begin
            offer = i_valid && !o_ready;
            nb    = i_in_byte;
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending.size() != 0) begin
                    if (pending[0] == HOLD_FOR_DRAIN) begin
                        if (!out_idle) drain_wait = 0;
                        else if (drain_wait < 6) drain_wait++;
                        else void'(pending.pop_front());
                    end else if (!calm && $urandom_range(0, 4) == 0) begin
                        send_gap = $urandom_range(1, 16);
                    end else begin
                        nb    = t_byte'(pending.pop_front());
                        offer = 1'b1;
                    end
                end
            end
            i_valid   <= offer;
            i_in_byte <= nb;
            calm      <= (pending.size() < CALM_TAIL);
        end
    end

    // Output receiver: random ready/stall bursts plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && n_taken >= 150) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            i_ready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run--;
            i_ready <= 1'b1;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_run = $urandom_range(1, 16) - 1;
            i_ready <= 1'b0;
        end else begin
            ready_run = $urandom_range(1, 16) - 1;
            i_ready <= 1'b1;
        end
    end

    // Check outputs against the queue, then predict from the accepted request.
    always @(posedge i_clk) begin : watch
        t_out_rec want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_out.size() == 0) begin
                    $error("out_byte: nothing expected, got %02h", o_out_byte);
                    n_fail++;
                end else begin
                    want = expected_out.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                        n_fail++;
                    end
                    if (o_last_of_run !== want.is_last) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.is_last, o_last_of_run);
                        n_fail++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                format_byte(i_in_byte);
                n_taken <= n_taken + 1;
            end
            out_idle <= (expected_out.size() == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_byte directed [28] = '{
            BYTE_NL, BYTE_NL, BYTE_STAR, 8'h61, BYTE_BLANK, BYTE_TAB, BYTE_BLANK,
            8'h62, BYTE_BLANK, BYTE_STAR, BYTE_BLANK, BYTE_BLANK, BYTE_NL, BYTE_NL,
            BYTE_NL, BYTE_MINUS, 8'h00, 8'hFF, BYTE_NL, BYTE_PLUS, 8'h0D, BYTE_TAB,
            BYTE_NL, 8'h7F, BYTE_BLANK, BYTE_BLANK, BYTE_NL, 8'h63
        };
        int    n_random;
        int    pick;
        int    len;
        int    w;
        logic  mid_drain;

        blank_run     = 2'd0;
        nl_run        = 2'd0;
        line_clear    = 1'b1;
        no_output_yet = 1'b1;

        // Leading newlines, list items, blank runs, saturation, hard break,
        // paragraph followed by a list item, odd byte values.
        foreach (directed[i]) pending = {pending, int'(directed[i])};
        pending = {pending, HOLD_FOR_DRAIN};

        n_random  = 0;
        mid_drain = 1'b0;
        while (n_random < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 7) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(8'h61, 8'h7A);
                    if (w == BYTE_BLANK || w == BYTE_TAB || w == BYTE_NL) w = 8'h2E;
                    pending = {pending, w};
                end
                n_random += len;
            end else if (pick < 11) begin
                len = $urandom_range(1, 4);
                repeat (len)
                    pending = {pending, int'($urandom_range(0, 1) ? BYTE_BLANK : BYTE_TAB)};
                n_random += len;
            end else if (pick < 14) begin
                len = $urandom_range(1, 3);
                repeat (len) pending = {pending, int'(BYTE_NL)};
                n_random += len;
            end else if (pick < 17) begin
                case ($urandom_range(0, 2))
                    0: pending = {pending, int'(BYTE_STAR)};
                    1: pending = {pending, int'(BYTE_PLUS)};
                    default: pending = {pending, int'(BYTE_MINUS)};
                endcase
                n_random++;
            end else begin
                pending = {pending, int'($urandom_range(0, 255))};
                n_random++;
            end
            if (!mid_drain && n_random >= 220) begin
                pending = {pending, HOLD_FOR_DRAIN};
                mid_drain = 1'b1;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_valid) @(negedge i_clk);
        while (expected_out.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
